>>> design/slps_pkg.sv
// Shared types and constants of the status LED priority sequencer.
`default_nettype none

package slps_pkg;

  // Poll runs on every POLL_PERIOD-th tick; the counter width covers the full range.
  localparam int unsigned POLL_PERIOD = 11;
  localparam int unsigned POLL_W      = 4;

  // Status flag bit positions.
  localparam int unsigned FLAG_HW    = 0;
  localparam int unsigned FLAG_SENS  = 1;
  localparam int unsigned FLAG_PAIR  = 2;
  localparam int unsigned FLAG_UPD   = 3;
  localparam int unsigned FLAG_HAND  = 4;
  localparam int unsigned FLAG_CLEAN = 5;
  localparam int unsigned FLAG_W     = 6;

  // Latched mode code when no mode has been latched.
  localparam logic [3:0] MODE_INVALID = 4'd8;

  // Register reset values.
  localparam logic [7:0] LEVEL_MAX_RST   = 8'd180;
  localparam logic [6:0] BREATH_STEP_RST = 7'd2;
  localparam logic [4:0] PEAK_HOLD_RST   = 5'd10;
  localparam logic [4:0] FLOOR_HOLD_RST  = 5'd20;
  localparam logic [6:0] WIFI_TICKS_RST  = 7'd100;
  localparam logic [1:0] BLINK_DIV_RST   = 2'd2;

  localparam logic [7:0] LEVEL_FULL = 8'd255;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_NIGHT  = 3'd1,
    MODE_SMART  = 3'd2,
    MODE_SLEEP  = 3'd3
  } op_mode_e;

  typedef enum logic [2:0] {
    CFG_LEVEL_MAX   = 3'd0,
    CFG_BREATH_STEP = 3'd1,
    CFG_PEAK_HOLD   = 3'd2,
    CFG_FLOOR_HOLD  = 3'd3,
    CFG_WIFI_TICKS  = 3'd4,
    CFG_BLINK_DIV   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic       hardware_error;
    logic       sensor_error;
    logic       pairing_active;
    logic       update_active;
    logic       hand_detected;
    logic       cleaning_active;
    logic       wifi_connected;
    logic [2:0] op_mode;
    logic       manual_override;
  } tick_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] white;
  } rgbw_t;

  typedef struct packed {
    rgbw_t colour;
    logic  refresh;
  } result_t;

  typedef struct packed {
    logic       vld;
    logic [2:0] index;
    logic [7:0] data;
  } cfg_wr_t;

endpackage

`default_nettype wire

>>> design/slps_ifs.sv
// Handshake interfaces for the tick, result and configuration channels.
`default_nettype none

interface slps_tick_if;
  logic       valid;
  logic       ready;
  logic       hardware_error;
  logic       sensor_error;
  logic       pairing_active;
  logic       update_active;
  logic       hand_detected;
  logic       cleaning_active;
  logic       wifi_connected;
  logic [2:0] op_mode;
  logic       manual_override;

  modport source (
    output valid, hardware_error, sensor_error, pairing_active, update_active,
           hand_detected, cleaning_active, wifi_connected, op_mode, manual_override,
    input  ready
  );
  modport sink (
    input  valid, hardware_error, sensor_error, pairing_active, update_active,
           hand_detected, cleaning_active, wifi_connected, op_mode, manual_override,
    output ready
  );
endinterface

interface slps_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] white;
  logic       refresh;

  modport source (output valid, red, green, blue, white, refresh, input ready);
  modport sink (input valid, red, green, blue, white, refresh, output ready);
endinterface

interface slps_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> design/slps_core.sv
// Sequencer state, configuration registers and the per-tick colour decision.
`default_nettype none

module slps_core import slps_pkg::*; (
  input  wire     clk_i,
  input  wire     rst_ni,
  input  cfg_wr_t cfg_i,
  input  wire     adv_i,
  input  tick_t   tick_i,
  output result_t res_o
);

  // Configuration registers.
  logic [7:0] level_max_q;
  logic [6:0] breath_step_q;
  logic [4:0] peak_hold_q;
  logic [4:0] floor_hold_q;
  logic [6:0] wifi_ticks_q;
  logic [1:0] blink_div_q;

  // Sequencer state.
  logic [FLAG_W-1:0] flags_q, flags_d;
  logic [POLL_W-1:0] poll_cnt_q, poll_cnt_d;
  logic [3:0]        mode_q, mode_d;
  logic [6:0]        wifi_cnt_q, wifi_cnt_d;
  logic [1:0]        blink_cnt_q, blink_cnt_d;
  logic              blink_phase_q, blink_phase_d;
  logic              br_active_q, br_active_d;
  logic [7:0]        br_level_q, br_level_d;
  logic              br_fall_q, br_fall_d;
  logic [4:0]        br_hold_q, br_hold_d;
  rgbw_t             colour_q, colour_d;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_max_q   <= LEVEL_MAX_RST;
      breath_step_q <= BREATH_STEP_RST;
      peak_hold_q   <= PEAK_HOLD_RST;
      floor_hold_q  <= FLOOR_HOLD_RST;
      wifi_ticks_q  <= WIFI_TICKS_RST;
      blink_div_q   <= BLINK_DIV_RST;
    end else if (cfg_i.vld) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_LEVEL_MAX:   level_max_q   <= cfg_i.data;
        CFG_BREATH_STEP: breath_step_q <= cfg_i.data[6:0];
        CFG_PEAK_HOLD:   peak_hold_q   <= cfg_i.data[4:0];
        CFG_FLOOR_HOLD:  floor_hold_q  <= cfg_i.data[4:0];
        CFG_WIFI_TICKS:  wifi_ticks_q  <= cfg_i.data[6:0];
        CFG_BLINK_DIV:   blink_div_q   <= cfg_i.data[1:0];
        default: ;
      endcase
    end
  end

  // One tick: flags, wifi event, poll, then the colour by priority.
  always_comb begin
    logic [FLAG_W-1:0] flags0;
    logic [FLAG_W-1:0] flags1;
    logic              poll_hit;
    logic              br_clr;
    logic [7:0]        lvl;
    logic              fall;
    logic [8:0]        sum;
    logic              show_en;
    rgbw_t             colour_new;

    flags_d       = flags_q;
    poll_cnt_d    = poll_cnt_q;
    mode_d        = mode_q;
    wifi_cnt_d    = wifi_cnt_q;
    blink_cnt_d   = blink_cnt_q;
    blink_phase_d = blink_phase_q;
    br_hold_d     = br_hold_q;
    show_en       = 1'b0;
    colour_new    = '0;

    // Non-hand flags come straight from the tick; the hand flag is kept.
    flags0             = '0;
    flags0[FLAG_HW]    = tick_i.hardware_error;
    flags0[FLAG_SENS]  = tick_i.sensor_error;
    flags0[FLAG_PAIR]  = tick_i.pairing_active;
    flags0[FLAG_UPD]   = tick_i.update_active;
    flags0[FLAG_HAND]  = flags_q[FLAG_HAND];
    flags0[FLAG_CLEAN] = tick_i.cleaning_active;

    // Wifi connect reloads the green countdown.
    if (tick_i.wifi_connected) begin
      wifi_cnt_d = wifi_ticks_q;
    end

    // Poll tick takes the hand reading.
    poll_hit = (poll_cnt_q >= POLL_W'(POLL_PERIOD - 1));
    poll_cnt_d = poll_hit ? '0 : poll_cnt_q + 1'b1;
    flags1 = flags0;
    if (poll_hit) begin
      flags1[FLAG_HAND] = tick_i.hand_detected;
    end
    flags_d = flags1;

    // Any flag change restarts the breathing ramp; the pause counter is kept.
    br_clr      = (flags0 != flags_q) || (flags1 != flags0);
    br_active_d = br_active_q & ~br_clr;
    br_level_d  = br_clr ? 8'd0 : br_level_q;
    br_fall_d   = br_fall_q & ~br_clr;

    // The mode is latched on a poll tick only when no flag is set.
    if (poll_hit && (mode_q != {1'b0, tick_i.op_mode}) && (flags1 == '0)) begin
      mode_d = {1'b0, tick_i.op_mode};
    end

    lvl  = br_level_d;
    fall = br_fall_d;
    sum  = '0;

    if (!tick_i.manual_override) begin
      if (flags1 != '0) begin
        mode_d = MODE_INVALID;
        if (flags1[FLAG_HW] || flags1[FLAG_SENS]) begin
          show_en        = 1'b1;
          colour_new.red = level_max_q;
        end else if (flags1[FLAG_PAIR]) begin
          // Breathing ramp: show the level, then pause or step and turn at the ends.
          if (!br_active_d) begin
            lvl  = 8'd0;
            fall = 1'b0;
          end
          br_active_d     = 1'b1;
          show_en         = 1'b1;
          colour_new.blue = lvl;
          br_level_d      = lvl;
          br_fall_d       = fall;
          if (br_hold_q != 5'd0) begin
            br_hold_d = br_hold_q - 1'b1;
          end else if (!fall) begin
            sum = {1'b0, lvl} + {2'b00, breath_step_q};
            if ((breath_step_q != 7'd0) && (sum >= {1'b0, LEVEL_FULL})) begin
              br_level_d = LEVEL_FULL;
              br_fall_d  = 1'b1;
              br_hold_d  = peak_hold_q;
            end else begin
              br_level_d = sum[7:0];
            end
          end else begin
            if ((breath_step_q != 7'd0) && (lvl <= {1'b0, breath_step_q})) begin
              br_level_d = 8'd0;
              br_fall_d  = 1'b0;
              br_hold_d  = floor_hold_q;
            end else begin
              br_level_d = lvl - {1'b0, breath_step_q};
            end
          end
        end else if (flags1[FLAG_UPD]) begin
          // Magenta blink toggles once the divider count is reached.
          if (blink_cnt_q >= blink_div_q) begin
            show_en     = 1'b1;
            blink_cnt_d = 2'd0;
            if (blink_phase_q) begin
              blink_phase_d   = 1'b0;
              colour_new.red  = level_max_q;
              colour_new.blue = level_max_q;
            end else begin
              blink_phase_d = 1'b1;
            end
          end else begin
            blink_cnt_d = blink_cnt_q + 1'b1;
          end
        end else begin
          show_en          = 1'b1;
          colour_new.green = level_max_q;
        end
      end else if (wifi_cnt_d != 7'd0) begin
        wifi_cnt_d       = wifi_cnt_d - 1'b1;
        show_en          = 1'b1;
        colour_new.green = level_max_q;
      end else begin
        show_en = 1'b1;
        case (mode_d)
          {1'b0, MODE_NIGHT}: colour_new.white = {1'b0, level_max_q[7:1]};
          {1'b0, MODE_SMART}: colour_new.blue  = level_max_q;
          {1'b0, MODE_SLEEP}: colour_new       = '0;
          default:            colour_new.white = level_max_q;
        endcase
      end
    end

    colour_d      = show_en ? colour_new : colour_q;
    res_o.colour  = colour_d;
    res_o.refresh = show_en && (colour_new != colour_q);
  end

  // State advances once per processed tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q       <= '0;
      poll_cnt_q    <= '0;
      mode_q        <= MODE_INVALID;
      wifi_cnt_q    <= '0;
      blink_cnt_q   <= '0;
      blink_phase_q <= 1'b0;
      br_active_q   <= 1'b0;
      br_level_q    <= '0;
      br_fall_q     <= 1'b0;
      br_hold_q     <= '0;
      colour_q      <= '0;
    end else if (adv_i) begin
      flags_q       <= flags_d;
      poll_cnt_q    <= poll_cnt_d;
      mode_q        <= mode_d;
      wifi_cnt_q    <= wifi_cnt_d;
      blink_cnt_q   <= blink_cnt_d;
      blink_phase_q <= blink_phase_d;
      br_active_q   <= br_active_d;
      br_level_q    <= br_level_d;
      br_fall_q     <= br_fall_d;
      br_hold_q     <= br_hold_d;
      colour_q      <= colour_d;
    end
  end

  // The poll counter never passes its period.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    poll_cnt_q < POLL_W'(POLL_PERIOD))
    else $error("poll counter out of range");

  // Without a processed tick the sequencer state holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> $stable(flags_q) && $stable(colour_q) && $stable(br_level_q)
               && $stable(poll_cnt_q) && $stable(mode_q))
    else $error("state moved without a tick");

  // An idle ramp always sits at zero, rising.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !br_active_q |-> (br_level_q == 8'd0) && !br_fall_q)
    else $error("inactive ramp not at floor");

  // A latched mode is always a three-bit mode code or the invalid marker.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_INVALID) || !mode_q[3])
    else $error("latched mode corrupt");

endmodule

`default_nettype wire

>>> design/status_led_priority_sequencer.sv
// Each accepted tick is held in the input register, then its result in the result register.
// Throughput: one tick per cycle while results are taken; the input and result
// registers decouple the channels, so one more tick is taken while a result waits.
// The per-tick colour decision is one pass of logic between those two registers.
// Reset clears the sequencer state and valid flags, restores register defaults and sets the held colour to all off.
`default_nettype none

module status_led_priority_sequencer import slps_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  slps_cfg_if.sink   cfg_i,
  slps_tick_if.sink  tick_i,
  slps_result_if.source result_o
);

  tick_t   tick_q;
  logic    tick_vld_q;
  result_t res_q;
  logic    res_vld_q;
  result_t core_res;
  cfg_wr_t cfg_wr;
  logic    adv;
  logic    tick_acc;

  // Configuration beats are always taken.
  assign cfg_i.ready  = 1'b1;
  assign cfg_wr.vld   = cfg_i.valid;
  assign cfg_wr.index = cfg_i.index;
  assign cfg_wr.data  = cfg_i.data;

  // Process the held tick when the result register is free or draining.
  assign adv          = tick_vld_q && (!res_vld_q || result_o.ready);
  assign tick_i.ready = !tick_vld_q || adv;
  assign tick_acc     = tick_i.valid && tick_i.ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_vld_q <= 1'b0;
    end else if (tick_acc) begin
      tick_vld_q <= 1'b1;
    end else if (adv) begin
      tick_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      tick_q.hardware_error  <= tick_i.hardware_error;
      tick_q.sensor_error    <= tick_i.sensor_error;
      tick_q.pairing_active  <= tick_i.pairing_active;
      tick_q.update_active   <= tick_i.update_active;
      tick_q.hand_detected   <= tick_i.hand_detected;
      tick_q.cleaning_active <= tick_i.cleaning_active;
      tick_q.wifi_connected  <= tick_i.wifi_connected;
      tick_q.op_mode         <= tick_i.op_mode;
      tick_q.manual_override <= tick_i.manual_override;
    end
  end

  slps_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_wr),
    .adv_i  (adv),
    .tick_i (tick_q),
    .res_o  (core_res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (adv) begin
      res_vld_q <= 1'b1;
    end else if (result_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= core_res;
    end
  end

  assign result_o.valid   = res_vld_q;
  assign result_o.red     = res_q.colour.red;
  assign result_o.green   = res_q.colour.green;
  assign result_o.blue    = res_q.colour.blue;
  assign result_o.white   = res_q.colour.white;
  assign result_o.refresh = res_q.refresh;

  // An empty input register always takes a beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tick_vld_q |-> tick_i.ready)
    else $error("input stalled while empty");

  // A stalled result with a tick waiting blocks further input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_vld_q && res_vld_q && !result_o.ready) |-> !tick_i.ready)
    else $error("input taken while full");

  // A manual override tick never flags a refresh.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && tick_q.manual_override) |=> !res_q.refresh)
    else $error("refresh under manual override");

endmodule

`default_nettype wire
